@@ sv/fixed_point_divide_saturating_macros.svh @@
// Assertion macros for the saturating fixed-point divider.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef FIXED_POINT_DIVIDE_SATURATING_MACROS_SVH
`define FIXED_POINT_DIVIDE_SATURATING_MACROS_SVH
`ifndef SYNTH
`define FPDS_ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("fpds assertion failed");
`define FPDS_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("fpds assertion failed");
`else
`define FPDS_ASSERT_SAME(label, clk, rst_n, cond, conseq)
`define FPDS_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

@@ sv/fpds_pkg.sv @@
`timescale 1ns / 1ps
package fpds_pkg;

    localparam int DataW    = 32;
    localparam int FracBits = 16;
    localparam int OvfShift = 14;
    // Quotient bits produced by the divide chain, one per stage.
    localparam int DqW      = FracBits + OvfShift;
    localparam int NumSteps = DqW;

    localparam logic [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

    typedef struct packed {
        logic signed [DataW-1:0] dividend;
        logic signed [DataW-1:0] divisor;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] quotient;
        logic                    saturated;
    } t_out_item;

    // One item in flight through the divide chain. The dq field starts as the
    // low numerator bits and fills with quotient bits from the right.
    typedef struct packed {
        logic [DataW-1:0] rem;
        logic [DqW-1:0]   dq;
        logic [DataW-1:0] mb;
        logic             neg;
        logic             sat;
    } t_stage;

endpackage

@@ sv/fixed_point_divide_saturating.sv @@
// Signed 16.16 saturating divider, restoring division with one quotient bit per stage.
// An accepted item passes through one operand stage, 30 divide stages and one output
// stage before its result reaches the output register.
// Throughput: one item per cycle while o_stall is low; the 30-stage divide chain holds up to 30 items.
// Reset (synchronous, active low) clears all valid bits; the payload is not reset.
`timescale 1ns / 1ps
`include "fixed_point_divide_saturating_macros.svh"
module fixed_point_divide_saturating (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fpds_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output fpds_pkg::t_out_item o_item
);

    logic                   w_en;
    logic                   w_valid [0:fpds_pkg::NumSteps];
    fpds_pkg::t_stage       w_stage [0:fpds_pkg::NumSteps];

    assign o_stall = ~w_en;

    fpds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (w_valid[0]),
        .o_stage (w_stage[0])
    );

    for (genvar k = 0; k < fpds_pkg::NumSteps; k++) begin : g_step
        fpds_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_stage (w_stage[k]),
            .o_valid (w_valid[k+1]),
            .o_stage (w_stage[k+1])
        );
    end

    fpds_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[fpds_pkg::NumSteps]),
        .i_stage (w_stage[fpds_pkg::NumSteps]),
        .i_stall (i_stall),
        .o_en    (w_en),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    // A full skid register always has an item waiting ahead of it.
    `FPDS_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, o_stall, o_valid)
    `FPDS_ASSERT_SAME(a_sat_value, i_clk, i_rst_n, o_valid && o_item.saturated, o_item.quotient == fpds_pkg::QMax || o_item.quotient == fpds_pkg::QMin)
    // An unsaturated quotient stays within 30 magnitude bits.
    `FPDS_ASSERT_SAME(a_unsat_range, i_clk, i_rst_n, o_valid && !o_item.saturated, o_item.quotient[31] == o_item.quotient[30])
    // An output held by a stall cannot be bumped by the skid entry.
    `FPDS_ASSERT_NEXT(a_stall_no_drain, i_clk, i_rst_n, o_valid && i_stall && o_stall, o_stall)

endmodule

@@ sv/fpds_front.sv @@
`timescale 1ns / 1ps
module fpds_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  fpds_pkg::t_in_item i_item,
    output logic              o_valid,
    output fpds_pkg::t_stage  o_stage
);

    logic [fpds_pkg::DataW-1:0] w_a;
    logic [fpds_pkg::DataW-1:0] w_b;
    logic [fpds_pkg::DataW-1:0] w_ma;
    logic [fpds_pkg::DataW-1:0] w_mb;
    logic [fpds_pkg::DataW-1:0] w_ma_hi;
    fpds_pkg::t_stage           n_stage;
    fpds_pkg::t_stage           r_stage;
    logic                       r_valid;

    assign w_a = $unsigned(i_item.dividend);
    assign w_b = $unsigned(i_item.divisor);

    // The most negative value negates to itself, which read unsigned is 2^31.
    assign w_ma = w_a[fpds_pkg::DataW-1] ? (~w_a + 1'b1) : w_a;
    assign w_mb = w_b[fpds_pkg::DataW-1] ? (~w_b + 1'b1) : w_b;
    assign w_ma_hi = {{fpds_pkg::OvfShift{1'b0}}, w_ma[fpds_pkg::DataW-1:fpds_pkg::OvfShift]};

    always_comb begin
        n_stage.rem = w_ma_hi;
        n_stage.dq  = {w_ma[fpds_pkg::OvfShift-1:0], {fpds_pkg::FracBits{1'b0}}};
        n_stage.mb  = w_mb;
        n_stage.neg = w_a[fpds_pkg::DataW-1] ^ w_b[fpds_pkg::DataW-1];
        n_stage.sat = (w_ma_hi >= w_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

@@ sv/fpds_div_step.sv @@
`timescale 1ns / 1ps
module fpds_div_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  fpds_pkg::t_stage i_stage,
    output logic             o_valid,
    output fpds_pkg::t_stage o_stage
);

    logic [fpds_pkg::DataW:0]   w_shifted;
    logic [fpds_pkg::DataW+1:0] w_diff;
    logic                       w_ge;
    fpds_pkg::t_stage           n_stage;
    fpds_pkg::t_stage           r_stage;
    logic                       r_valid;

    // Bring down the next numerator bit and try one subtraction.
    assign w_shifted = {i_stage.rem, i_stage.dq[fpds_pkg::DqW-1]};
    assign w_diff    = {1'b0, w_shifted} - {2'b00, i_stage.mb};
    assign w_ge      = ~w_diff[fpds_pkg::DataW+1];

    always_comb begin
        n_stage     = i_stage;
        n_stage.rem = w_ge ? w_diff[fpds_pkg::DataW-1:0] : w_shifted[fpds_pkg::DataW-1:0];
        n_stage.dq  = {i_stage.dq[fpds_pkg::DqW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

@@ sv/fpds_out.sv @@
`timescale 1ns / 1ps
module fpds_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fpds_pkg::t_stage   i_stage,
    input  logic               i_stall,
    output logic               o_en,
    output logic               o_valid,
    output fpds_pkg::t_out_item o_item
);

    logic [fpds_pkg::DataW-1:0] w_mag;
    fpds_pkg::t_out_item        n_item;
    fpds_pkg::t_out_item        r_out;
    fpds_pkg::t_out_item        r_skid;
    logic                       r_out_valid;
    logic                       r_skid_valid;
    logic                       w_out_free;
    logic                       w_arrive;

    assign w_mag = {{(fpds_pkg::DataW-fpds_pkg::DqW){1'b0}}, i_stage.dq};

    always_comb begin
        n_item.saturated = i_stage.sat;
        if (i_stage.sat) begin
            n_item.quotient = i_stage.neg ? fpds_pkg::QMin : fpds_pkg::QMax;
        end else begin
            n_item.quotient = i_stage.neg ? (~w_mag + 1'b1) : w_mag;
        end
    end

    // The chain advances only while the skid register is empty, so the
    // upstream stall comes straight from a flip-flop.
    assign o_en       = ~r_skid_valid;
    assign w_out_free = ~r_out_valid | ~i_stall;
    assign w_arrive   = o_en & i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid | w_arrive;
            r_skid_valid <= 1'b0;
        end else if (w_arrive) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : n_item;
        end else if (w_arrive) begin
            r_skid <= n_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
